// ===== rtl/core/ptc_pkg.sv =====
// Shared types and constants for the prime test and count block.
package ptc_pkg;

  localparam int PTC_VALUE_W = 32;
  localparam int PTC_COUNT_W = 16;

  // First odd trial divisor and the step between trial divisors.
  localparam logic [PTC_VALUE_W-1:0] PTC_FIRST_DIV = PTC_VALUE_W'(3);
  localparam logic [PTC_VALUE_W-1:0] PTC_DIV_STEP  = PTC_VALUE_W'(2);
  localparam logic [PTC_VALUE_W-1:0] PTC_TWO       = PTC_VALUE_W'(2);

  typedef struct packed {
    logic signed [PTC_VALUE_W-1:0] value;
    logic                          last;
  } ptc_in_t;

  typedef struct packed {
    logic                   is_prime;
    logic [PTC_COUNT_W-1:0] prime_count;
    logic                   last_out;
  } ptc_out_t;

  // Status from the serial divider to the sequencer.
  typedef struct packed {
    logic                   done;
    logic [PTC_VALUE_W-1:0] quot;
    logic [PTC_VALUE_W-1:0] rem;
  } ptc_div_res_t;

endpackage

// ===== rtl/core/ptc_div.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
module ptc_div
  import ptc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [PTC_VALUE_W-1:0] dividend,
  input  logic [PTC_VALUE_W-1:0] divisor,
  output ptc_div_res_t           res
);

  localparam int CNT_W = $clog2(PTC_VALUE_W);

  logic                   busy;
  logic                   done;
  logic [CNT_W-1:0]       cnt;
  logic [PTC_VALUE_W-1:0] acc;
  logic [PTC_VALUE_W-1:0] quo;
  logic [PTC_VALUE_W-1:0] dvs;
  logic [PTC_VALUE_W:0]   shifted;
  logic [PTC_VALUE_W:0]   diff;
  logic                   fits;

  // shift in next dividend bit, try to subtract the divisor
  assign shifted = {acc, quo[PTC_VALUE_W-1]};
  assign diff    = shifted - {1'b0, dvs};
  assign fits    = shifted >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        acc  <= '0;
        quo  <= dividend;
        dvs  <= divisor;
        cnt  <= CNT_W'(PTC_VALUE_W - 1);
      end else if (busy) begin
        acc <= fits ? diff[PTC_VALUE_W-1:0] : shifted[PTC_VALUE_W-1:0];
        quo <= {quo[PTC_VALUE_W-2:0], fits};
        cnt <= cnt - CNT_W'(1);
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res.done = done;
  assign res.quot = quo;
  assign res.rem  = acc;

endmodule

// ===== rtl/core/prime_test_and_count.sv =====
// Top level: trial-division primality test with a per-set prime counter.
// Words that are negative, below 3 or even are settled without division; otherwise
//   each of k odd trial divisors takes one serial division of W = 32 bit steps.
// Worst case about 23170 divisors per word; one word at a time.
// The output register lets the next word be taken while a result waits.
// Reset (rst, synchronous): sequencer idle, no result pending, set count zero.
module prime_test_and_count
  import ptc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     item_valid,
  output logic     item_ready,
  input  ptc_in_t  item,
  output logic     res_valid,
  input  logic     res_ready,
  output ptc_out_t res
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_DONE
  } state_t;

  state_t                 state;
  logic [PTC_VALUE_W-1:0] value;       // held word under test
  logic                   last;
  logic [PTC_VALUE_W-1:0] divisor;     // current odd trial divisor
  logic                   prime;
  logic                   div_start;
  logic [PTC_COUNT_W-1:0] running_count;
  logic [PTC_COUNT_W-1:0] count_next;
  ptc_div_res_t           div_res;

  logic in_neg;
  logic in_below2;
  logic in_two;
  logic in_even;
  logic in_short;
  logic push;

  // Cheap classification on the incoming word; only odd values of 3 and
  // above go through trial division.
  assign in_neg    = item.value[PTC_VALUE_W-1];
  assign in_below2 = (item.value[PTC_VALUE_W-1:1] == '0);
  assign in_two    = (item.value == PTC_TWO);
  assign in_even   = !item.value[0];
  assign in_short  = in_neg || in_below2 || in_even;

  assign item_ready = (state == S_IDLE);

  // Output register free, or being emptied this cycle
  assign push = (state == S_DONE) && (!res_valid || res_ready);

  // Saturating count including the current word
  assign count_next = (prime && (running_count != '1)) ?
                      running_count + PTC_COUNT_W'(1) : running_count;

  ptc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (value),
    .divisor  (divisor),
    .res      (div_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      res_valid     <= 1'b0;
      div_start     <= 1'b0;
      running_count <= '0;
    end else begin
      // a push in the same cycle keeps the output register full
      if (res_valid && res_ready && !push) begin
        res_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          div_start <= item_valid && !in_short;
          if (item_valid) begin
            value   <= item.value;
            last    <= item.last;
            divisor <= PTC_FIRST_DIV;
            if (in_short) begin
              // covers 2 as the only even prime
              prime <= in_two;
              state <= S_DONE;
            end else begin
              state <= S_DIV;
            end
          end
        end
        S_DIV: begin
          // next trial only while the bound holds and no factor has turned up
          div_start <= div_res.done && (divisor <= div_res.quot) &&
                       (div_res.rem != '0);
          if (div_res.done) begin
            if (divisor > div_res.quot) begin
              // divisor squared now exceeds the value: no factor found
              prime <= 1'b1;
              state <= S_DONE;
            end else if (div_res.rem == '0) begin
              prime <= 1'b0;
              state <= S_DONE;
            end else begin
              divisor <= divisor + PTC_DIV_STEP;
            end
          end
        end
        S_DONE: begin
          div_start <= 1'b0;
          if (push) begin
            res_valid       <= 1'b1;
            res.is_prime    <= prime;
            res.prime_count <= count_next;
            res.last_out    <= last;
            running_count   <= last ? '0 : count_next;
            state           <= S_IDLE;
          end
        end
        default: begin
          div_start <= 1'b0;
          state     <= S_IDLE;
        end
      endcase
    end
  end

  // Trial divisors are always odd and at least three while dividing
  a_div_odd: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (divisor[0] && (divisor >= PTC_FIRST_DIV)))
    else $error("trial divisor not odd or below three");

  // Divider only finishes while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_res.done |-> (state == S_DIV))
    else $error("divider finished outside trial division");

  // A composite word leaves the count unchanged
  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    (push && !prime) |=> (res.prime_count == $past(running_count)))
    else $error("count moved on a non-prime word");

  // A new result always comes from the done state
  a_push_src: assert property (@(posedge clk) disable iff (rst)
    (!res_valid ##1 res_valid) |-> $past(state == S_DONE))
    else $error("result issued outside done state");

endmodule

// ===== sim/tb_prime_test_and_count.sv =====
// Testbench for prime_test_and_count: directed, long set, hold-off and random sets.
module tb_prime_test_and_count;
  import ptc_pkg::*;

  // Largest set count; the counter sticks here until the set ends.
  localparam logic [PTC_COUNT_W-1:0] COUNT_FULL = '1;
  // Quick primes in one long set.
  localparam int LONG_SET_WORDS = 16;
  localparam int RANDOM_WORDS   = 50;
  // Long receiver hold-off: the block holds at most two words, so the input stalls.
  localparam int LONG_HOLD    = 300;
  // Drain window that covers the tail after the last result.
  localparam int DRAIN_CYCLES = 40;

  logic     clk        = 1'b0;
  logic     rst        = 1'b1;
  logic     item_valid = 1'b0;
  logic     item_ready;
  ptc_in_t  item       = '0;
  logic     res_valid;
  logic     res_ready  = 1'b0;
  ptc_out_t res;

  // Expected result words, oldest first, and the predicted set count.
  ptc_out_t               verdict_q[$];
  logic [PTC_COUNT_W-1:0] set_primes = '0;
  ptc_out_t               want;
  int                     mismatches = 0;

  // Sender burst/gap control and receiver stall control.
  bit          idle_en    = 1'b0;
  bit          stall_en   = 1'b0;
  int          burst_left = 0;
  int          hold_trigger = 0;
  int          hold_seen  = 0;
  int          hold_left  = 0;
  logic [15:0] stall_pat  = 16'hFFFF;
  int          pat_pos    = 0;

  prime_test_and_count dut (
    .clk       (clk),
    .rst       (rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item      (item),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Trial division over odd divisors; the bound is written as d <= v / d so it
  // never overflows. Negative values fall out on the sign bit.
  function automatic bit prime_by_division(logic [PTC_VALUE_W-1:0] v);
    logic [PTC_VALUE_W-1:0] d;
    if (v[PTC_VALUE_W-1]) return 1'b0;
    if (v < PTC_TWO) return 1'b0;
    if (v == PTC_TWO) return 1'b1;
    if (!v[0]) return 1'b0;
    for (d = PTC_FIRST_DIV; d <= v / d; d = d + PTC_DIV_STEP) begin
      if (v % d == '0) return 1'b0;
    end
    return 1'b1;
  endfunction

  // Predict the result word for one accepted word and update the set count.
  // The count reported includes this word; a set end clears it afterwards.
  function automatic void predict_verdict(ptc_in_t w);
    ptc_out_t r;
    bit       p;
    p = prime_by_division(w.value);
    if (p && set_primes != COUNT_FULL) set_primes = set_primes + PTC_COUNT_W'(1);
    r.is_prime    = p;
    r.prime_count = set_primes;
    r.last_out    = w.last;
    verdict_q.push_back(r);
    if (w.last) set_primes = '0;
  endfunction

  function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endfunction

  // Both handshakes are sampled at the rising edge, before the block's own
  // updates land. A result can never leave in the cycle its word arrives,
  // so checking before predicting is safe.
  always @(posedge clk) begin
    if (!rst) begin
      if (res_valid && res_ready) begin
        if (verdict_q.size() == 0) begin
          $display("%0t: result word %h with nothing expected", $time, res);
          mismatches++;
        end else begin
          want = verdict_q.pop_front();
          compare_field("is_prime", 32'(want.is_prime), 32'(res.is_prime));
          compare_field("prime_count", 32'(want.prime_count), 32'(res.prime_count));
          compare_field("last_out", 32'(want.last_out), 32'(res.last_out));
        end
      end
      if (item_valid && item_ready) predict_verdict(item);
    end
  end

  // Receiver: a long hold-off when asked for, otherwise a rolling 16-bit
  // stall pattern that is redrawn each lap (at least a quarter of laps never stall).
  always @(negedge clk) begin
    if (hold_seen != hold_trigger) begin
      hold_seen = hold_trigger;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else if (!stall_en) begin
      res_ready <= 1'b1;
    end else begin
      res_ready <= stall_pat[pat_pos];
      pat_pos++;
      if (pat_pos == 16) begin
        pat_pos   = 0;
        stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
      end
    end
  end

  // Offer one word from a falling edge and return at the falling edge after
  // it is taken. Valid is left high so the next word follows without a gap;
  // it only drops at the start of a random gap between bursts.
  task automatic send_word(input logic signed [PTC_VALUE_W-1:0] v, input logic l);
    int gap;
    if (idle_en) begin
      if (burst_left == 0) begin
        gap = $urandom_range(0, 6);
        if (gap != 0) begin
          item_valid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 12);
      end
      burst_left--;
    end
    item_valid <= 1'b1;
    item.value <= v;
    item.last  <= l;
    @(posedge clk);
    while (!item_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Random value: mostly small so trial division stays short, plus negatives,
  // large evens and large odd multiples of 3, 5 or 7, all of which exit early.
  function automatic logic [PTC_VALUE_W-1:0] rand_value();
    int unsigned            sel;
    int unsigned            m;
    int unsigned            q;
    logic [PTC_VALUE_W-1:0] v;
    sel = $urandom_range(0, 99);
    if (sel < 45) begin
      v = $urandom_range(0, 4095);
    end else if (sel < 55) begin
      v = $urandom_range(4096, 16383);
    end else if (sel < 67) begin
      v = $urandom;
      v[PTC_VALUE_W-1] = 1'b1;
    end else if (sel < 79) begin
      v = $urandom;
      v[PTC_VALUE_W-1] = 1'b0;
      v[0] = 1'b0;
    end else if (sel < 93) begin
      m = 3 + 2 * $urandom_range(0, 2);
      q = $urandom_range(1, 32'h7FFF_FFFF / m - 1) | 1;
      v = m * q;
    end else begin
      v = $urandom_range(0, 3);
    end
    return v;
  endfunction

  // Field extremes, the smallest primes, odd squares at the divisor bound,
  // and the largest positive value, which is prime and runs the full search.
  task automatic test_value_edges();
    idle_en  = 1'b1;
    stall_en = 1'b1;
    send_word(32'sh8000_0000, 1'b0);
    send_word(-32'sd1, 1'b0);
    send_word(32'sd0, 1'b0);
    send_word(32'sd1, 1'b0);
    send_word(32'sd2, 1'b0);
    send_word(32'sd3, 1'b0);
    send_word(32'sd4, 1'b0);
    send_word(32'sd9, 1'b0);
    send_word(32'sd25, 1'b0);
    send_word(32'sd49, 1'b0);
    send_word(32'sd15, 1'b0);
    send_word(32'sd17, 1'b0);
    send_word(32'sh7FFF_FFFE, 1'b0);
    send_word(32'sh7FFF_FFFD, 1'b0);
    send_word(32'sh7FFF_FFFF, 1'b1);
  endtask

  // Set ends: single-word sets, a set with no primes, and a set closed by a
  // non-prime word whose total still counts the earlier primes.
  task automatic test_set_ends();
    send_word(32'sd5, 1'b1);
    send_word(32'sd7, 1'b1);
    send_word(32'sd8, 1'b1);
    send_word(32'sd11, 1'b0);
    send_word(32'sd13, 1'b0);
    send_word(32'sd0, 1'b1);
    send_word(32'sd2, 1'b0);
  endtask

  // A long set of quick primes (2, 3, 5, 7) with a composite near the end,
  // then close the set and check that the next set starts from zero.
  // No idling, for speed.
  task automatic test_long_set();
    idle_en  = 1'b0;
    stall_en = 1'b0;
    for (int i = 0; i < LONG_SET_WORDS; i++) begin
      send_word((i % 4 == 0) ? 32'sd2 : 32'(2 * (i % 4) + 1), 1'b0);
    end
    send_word(32'sd9, 1'b0);
    send_word(32'sd11, 1'b1);
    send_word(32'sd13, 1'b1);
  endtask

  // Receiver holds off for a long stretch while words keep coming, so the
  // output register and the word in flight fill and the input stalls.
  task automatic test_output_hold();
    idle_en  = 1'b0;
    stall_en = 1'b1;
    hold_trigger++;
    for (int i = 0; i < 12; i++) begin
      send_word(32'($urandom_range(0, 255)), (i % 5) == 4);
    end
  endtask

  // Random sets of one to ten words with bursty input and a stalling receiver.
  task automatic test_random_sets();
    int left;
    left     = 0;
    idle_en  = 1'b1;
    stall_en = 1'b1;
    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (left == 0) left = $urandom_range(1, 10);
      left--;
      send_word(rand_value(), left == 0);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_value_edges();
    test_set_ends();
    test_long_set();
    test_output_hold();
    test_random_sets();

    item_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    // Any stray word in this window is caught by the checker.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog: the largest prime alone, with its full search, takes far longer
  // than the rest of the run; the timeout allows several times the whole run.
  initial begin
    #60_000_000;
    $display("timeout with %0d result words outstanding", verdict_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
